// ----- rtl/core/slipfd_pkg.sv -----
// ----------------------------------------------------------------------------
// slipfd_pkg
// Shared types and constants for the SLIP frame decoder.
// ----------------------------------------------------------------------------
package slipfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_END_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ESCAPE_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ZERO_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN   = 3'd5;

  // reset values
  localparam logic [BYTE_W-1:0] RST_END_CODE        = 8'd192;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE     = 8'd219;
  localparam logic [BYTE_W-1:0] RST_ESC_END_CODE    = 8'd220;
  localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE_CODE = 8'd221;
  localparam logic [BYTE_W-1:0] RST_ESC_ZERO_CODE   = 8'd222;
  localparam logic [LEN_W-1:0]  RST_MAX_FRAME_LEN   = 16'd1500;

  // byte that the escaped zero code decodes to
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] escaped_end_code;
    logic [BYTE_W-1:0] escaped_escape_code;
    logic [BYTE_W-1:0] escaped_zero_code;
    logic [LEN_W-1:0]  max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_last;
    logic [LEN_W-1:0]  frame_length;
    logic              escape_error;
    logic              length_overflow;
  } res_t;

endpackage

// ----- rtl/core/slipfd_cfg.sv -----
// ----------------------------------------------------------------------------
// slipfd_cfg
// Configuration register file for the SLIP frame decoder.
// ----------------------------------------------------------------------------
module slipfd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slipfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slipfd_pkg::LEN_W-1:0]    cfg_data,
  output slipfd_pkg::cfg_t                cfg
);
  import slipfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_END_CODE:        cfg_nxt.end_code            = cfg_data[BYTE_W-1:0];
        REG_ESCAPE_CODE:     cfg_nxt.escape_code         = cfg_data[BYTE_W-1:0];
        REG_ESC_END_CODE:    cfg_nxt.escaped_end_code    = cfg_data[BYTE_W-1:0];
        REG_ESC_ESCAPE_CODE: cfg_nxt.escaped_escape_code = cfg_data[BYTE_W-1:0];
        REG_ESC_ZERO_CODE:   cfg_nxt.escaped_zero_code   = cfg_data[BYTE_W-1:0];
        REG_MAX_FRAME_LEN:   cfg_nxt.max_frame_len       = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_code            <= RST_END_CODE;
      cfg_r.escape_code         <= RST_ESCAPE_CODE;
      cfg_r.escaped_end_code    <= RST_ESC_END_CODE;
      cfg_r.escaped_escape_code <= RST_ESC_ESCAPE_CODE;
      cfg_r.escaped_zero_code   <= RST_ESC_ZERO_CODE;
      cfg_r.max_frame_len       <= RST_MAX_FRAME_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/slipfd_dec.sv -----
// ----------------------------------------------------------------------------
// slipfd_dec
// Input register, frame state and one-byte decode step.
// ----------------------------------------------------------------------------
module slipfd_dec (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slipfd_pkg::BYTE_W-1:0] in_rx_byte,
  input  slipfd_pkg::cfg_t             cfg,
  input  logic                         slot_free,
  output slipfd_pkg::res_t             res
);
  import slipfd_pkg::*;

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              esc_r, esc_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic              ovf_r, ovf_nxt;

  logic              fire;
  logic              take;
  logic [BYTE_W-1:0] dec_byte;

  assign fire     = vld_r && slot_free;
  assign in_ready = !vld_r || slot_free;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    esc_nxt      = esc_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    ovf_nxt      = ovf_r;
    take         = 1'b0;
    dec_byte     = byte_r;
    res          = '0;

    if (fire) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        take    = 1'b1;
        if (byte_r == cfg.escaped_end_code) begin
          dec_byte = cfg.end_code;
        end else if (byte_r == cfg.escaped_escape_code) begin
          dec_byte = cfg.escape_code;
        end else if (byte_r == cfg.escaped_zero_code) begin
          dec_byte = ZERO_BYTE;
        end else begin
          err_nxt = 1'b1;
        end
      end else if (byte_r == cfg.end_code) begin
        // close the frame, nothing out for an empty one
        res.valid           = held_vld_r;
        res.data_byte       = held_r;
        res.frame_last      = 1'b1;
        res.frame_length    = cnt_r;
        res.escape_error    = err_r;
        res.length_overflow = ovf_r;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
        cnt_nxt      = '0;
        err_nxt      = 1'b0;
        ovf_nxt      = 1'b0;
      end else if (byte_r == cfg.escape_code) begin
        esc_nxt = 1'b1;
      end else begin
        take = 1'b1;
      end

      if (take) begin
        if (cnt_r >= cfg.max_frame_len) begin
          ovf_nxt = 1'b1;
        end else begin
          res.valid     = held_vld_r;
          res.data_byte = held_r;
          held_nxt      = dec_byte;
          held_vld_nxt  = 1'b1;
          cnt_nxt       = cnt_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
    if (!rst_n) begin
      vld_r      <= 1'b0;
      esc_r      <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      cnt_r      <= '0;
      err_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      esc_r      <= esc_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/core/slipfd_out.sv -----
// ----------------------------------------------------------------------------
// slipfd_out
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module slipfd_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slipfd_pkg::res_t             res,
  output logic                         slot_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slipfd_pkg::BYTE_W-1:0] out_data_byte,
  output logic                         out_frame_last,
  output logic [slipfd_pkg::LEN_W-1:0]  out_frame_length,
  output logic                         out_escape_error,
  output logic                         out_length_overflow
);
  import slipfd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      res_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data_byte       = res_r.data_byte;
  assign out_frame_last      = res_r.frame_last;
  assign out_frame_length    = res_r.frame_length;
  assign out_escape_error    = res_r.escape_error;
  assign out_length_overflow = res_r.length_overflow;

endmodule

// ----- rtl/core/slip_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Removes SLIP framing from a received byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  in_     | in        | rx_byte                                  | valid/ready
//  out_    | out       | data_byte, frame_last, frame_length,     | valid/ready
//          |           | escape_error, length_overflow            |
//  cfg_    | in        | index (3b), data (16b)                   | valid/ready
//
//  one byte per cycle sustained while the output is not stalled; a result
//  passes the input register, then the decode step into the result register,
//  before it is offered on the output channel
//  synchronous active-low reset restores the default codes, max length 1500
//  and clears all frame state
//  a stalled output holds the result; the input register still drains into
//  the result register in the same cycle the output transaction completes
//  cfg_ready is always high; writes are expected only while idle
// ----------------------------------------------------------------------------
module slip_frame_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [slipfd_pkg::BYTE_W-1:0]    in_rx_byte,
  // decoded output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slipfd_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                            out_frame_last,
  output logic [slipfd_pkg::LEN_W-1:0]     out_frame_length,
  output logic                            out_escape_error,
  output logic                            out_length_overflow,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slipfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slipfd_pkg::LEN_W-1:0]     cfg_data
);
  import slipfd_pkg::*;

  cfg_t cfg;       // current codes and length limit
  res_t res;       // decode step result, valid when a byte goes out
  logic slot_free; // result register can take a new result this cycle

  // configuration registers
  slipfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, escape/hold/count state and the decode step
  slipfd_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg),
    .slot_free  (slot_free),
    .res        (res)
  );

  // result register toward the output channel
  slipfd_out u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res                 (res),
    .slot_free           (slot_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_frame_last      (out_frame_last),
    .out_frame_length    (out_frame_length),
    .out_escape_error    (out_escape_error),
    .out_length_overflow (out_length_overflow)
  );

endmodule

// ----- rtl/core/slipfd_chk.sv -----
// ----------------------------------------------------------------------------
// slipfd_chk
// Port-level checks for the SLIP frame decoder.
// ----------------------------------------------------------------------------
module slipfd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [slipfd_pkg::BYTE_W-1:0]    out_data_byte,
  input logic                            out_frame_last,
  input logic [slipfd_pkg::LEN_W-1:0]     out_frame_length,
  input logic                            out_escape_error,
  input logic                            out_length_overflow
);
  import slipfd_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_frame_last) && $stable(out_frame_length))
    else $error("stalled result changed");

  // mid-frame bytes carry no frame status
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |->
      out_frame_length == '0 && !out_escape_error && !out_length_overflow)
    else $error("status on non-last byte");

  // a closed frame always holds at least one byte
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_frame_length != '0)
    else $error("empty frame delivered");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind slip_frame_decoder slipfd_chk u_chk (.*);
